// File: sv/scrw_pkg.sv
// Shared constants and types for the STX/ETX configuration record writer.
// Used by stx_etx_config_record_writer; no dependencies.
`default_nettype none

package scrw_pkg;

    // Frame layout
    localparam int MESSAGE_LEN  = 8;
    localparam int RECORD_BYTES = 8;
    localparam int STORE_DEPTH  = 8;
    localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
    localparam int COUNT_W      = $clog2(MESSAGE_LEN + 2);

    // Framing characters
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 21;
    localparam int CODE_W  = 8;
    localparam int DATA_W  = 8 * STORE_DEPTH;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REGION_START     = 3'd0,
        REG_REGION_SIZE      = 3'd1,
        REG_CODE_TACTILE     = 3'd2,
        REG_CODE_TEMPERATURE = 3'd3,
        REG_CODE_ERASE       = 3'd4,
        REG_CODE_READY       = 3'd5
    } t_reg_index;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_PROGRAM = 2'd1,
        ACT_ERASE   = 2'd2,
        ACT_REJECT  = 2'd3
    } t_action;

    // Register reset values
    localparam logic [ADDR_W-1:0] REGION_START_RST = '0;
    localparam logic [SIZE_W-1:0] REGION_SIZE_RST  = SIZE_W'(2048);
    localparam logic [CODE_W-1:0] CODE_TACTILE_RST = 8'd1;
    localparam logic [CODE_W-1:0] CODE_TEMP_RST    = 8'd2;
    localparam logic [CODE_W-1:0] CODE_ERASE_RST   = 8'd3;
    localparam logic [CODE_W-1:0] CODE_READY_RST   = 8'd4;

endpackage

`default_nettype wire

// File: sv/stx_etx_config_record_writer.sv
// Top level of the STX/ETX configuration record writer: framing, record
// pointer and result register. Depends on scrw_pkg.
`default_nettype none

// Takes one item (a received byte or a timer tick) per cycle and returns one
// result item for each. An item is held in the input register, then the
// frame logic and the record pointer update as it moves into the output
// register, so the sustained rate is one item per cycle; only a stall on the
// result side slows the input side. While a result waits, the input register
// takes one more item and then stalls the input until the result is taken.
// A frame opens on STX, stores its bytes, and closes on ETX once exactly
// MESSAGE_LEN bytes are in; its first byte selects program, erase or ready.
// Configuration writes are taken at any time but are meant for an idle block;
// writing the region start also reloads the record pointer.
module stx_etx_config_record_writer
    import scrw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // Configuration write port
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,

    // Input channel
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_kind,
    input  wire logic [7:0]           i_rx_byte,

    // Result channel
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [1:0]                o_action,
    output logic [ADDR_W-1:0]         o_flash_address,
    output logic [DATA_W-1:0]         o_program_data,
    output logic                      o_config_ready,
    output logic [ADDR_W-1:0]         o_tactile_start_address,
    output logic                      o_tactile_start_valid,
    output logic [ADDR_W-1:0]         o_temperature_start_address,
    output logic                      o_temperature_start_valid
);

    // Configuration registers
    logic [ADDR_W-1:0] r_region_start, n_region_start;
    logic [SIZE_W-1:0] r_region_size,  n_region_size;
    logic [ADDR_W:0]   r_region_end,   n_region_end;
    logic [CODE_W-1:0] r_code_tactile, n_code_tactile;
    logic [CODE_W-1:0] r_code_temp,    n_code_temp;
    logic [CODE_W-1:0] r_code_erase,   n_code_erase;
    logic [CODE_W-1:0] r_code_ready,   n_code_ready;

    // Frame and record state
    logic               r_receiving,   n_receiving;
    logic [COUNT_W-1:0] r_frame_count, n_frame_count;
    logic [1:0]         r_idle_ticks,  n_idle_ticks;
    logic [ADDR_W-1:0]  r_write_ptr,   n_write_ptr;
    logic [ADDR_W-1:0]  r_tact_start,  n_tact_start;
    logic               r_tact_seen,   n_tact_seen;
    logic [ADDR_W-1:0]  r_temp_start,  n_temp_start;
    logic               r_temp_seen,   n_temp_seen;
    logic               r_ready_flag,  n_ready_flag;
    logic [7:0]         r_store [STORE_DEPTH];

    // Input register
    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_byte;

    // Output register
    logic              r_out_valid;
    t_action           r_out_action;
    logic [ADDR_W-1:0] r_out_addr;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_ready;
    logic [ADDR_W-1:0] r_out_tact_start;
    logic              r_out_tact_seen;
    logic [ADDR_W-1:0] r_out_temp_start;
    logic              r_out_temp_seen;

    // Step results
    t_action           step_action;
    logic [ADDR_W-1:0] step_addr;
    logic [DATA_W-1:0] step_data;
    logic              store_we;
    logic [ADDR_W:0]   ptr_next;
    logic              region_full;
    logic [DATA_W-1:0] record_word;

    // Handshake: advance the input register into the output register
    logic advance;
    logic in_load;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign in_load = !r_in_valid || advance;
    assign o_stall = !in_load;

    // Record bounds and data
    assign ptr_next    = {1'b0, r_write_ptr} + (ADDR_W+1)'(RECORD_BYTES);
    assign region_full = ({1'b0, r_write_ptr} >= r_region_end) ||
                         (ptr_next > {1'b1, {ADDR_W{1'b0}}});

    always_comb begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
            record_word[8*k +: 8] = r_store[k];
        end
    end

    // Configuration writes
    always_comb begin
        n_region_start = r_region_start;
        n_region_size  = r_region_size;
        n_code_tactile = r_code_tactile;
        n_code_temp    = r_code_temp;
        n_code_erase   = r_code_erase;
        n_code_ready   = r_code_ready;
        if (i_cfg_wr_en) begin
            case (t_reg_index'(i_cfg_index))
                REG_REGION_START:     n_region_start = i_cfg_data;
                REG_REGION_SIZE:      n_region_size  = i_cfg_data[SIZE_W-1:0];
                REG_CODE_TACTILE:     n_code_tactile = i_cfg_data[CODE_W-1:0];
                REG_CODE_TEMPERATURE: n_code_temp    = i_cfg_data[CODE_W-1:0];
                REG_CODE_ERASE:       n_code_erase   = i_cfg_data[CODE_W-1:0];
                REG_CODE_READY:       n_code_ready   = i_cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
        n_region_end = {1'b0, n_region_start} + (ADDR_W+1)'(n_region_size);
    end

    // Frame step for the item leaving the input register
    always_comb begin
        n_receiving   = r_receiving;
        n_frame_count = r_frame_count;
        n_idle_ticks  = r_idle_ticks;
        n_write_ptr   = r_write_ptr;
        n_tact_start  = r_tact_start;
        n_tact_seen   = r_tact_seen;
        n_temp_start  = r_temp_start;
        n_temp_seen   = r_temp_seen;
        n_ready_flag  = r_ready_flag;
        step_action   = ACT_NONE;
        step_addr     = '0;
        step_data     = '0;
        store_we      = 1'b0;

        if (advance) begin
            if (r_in_kind == KIND_TICK) begin
                // Count ticks, saturate at three
                if (r_idle_ticks != 2'd3) begin
                    n_idle_ticks = r_idle_ticks + 2'd1;
                end
            end else if (r_in_byte == STX_BYTE && (!r_receiving || r_idle_ticks[1])) begin
                // Open a new frame
                n_receiving   = 1'b1;
                n_frame_count = '0;
                n_idle_ticks  = '0;
            end else if (r_receiving && r_in_byte == ETX_BYTE &&
                         r_frame_count == COUNT_W'(MESSAGE_LEN)) begin
                // Close the frame and act on its type byte
                n_receiving = 1'b0;
                if (r_store[0] == r_code_tactile || r_store[0] == r_code_temp) begin
                    if (r_store[0] == r_code_tactile) begin
                        if (!r_tact_seen) begin
                            n_tact_start = r_write_ptr;
                            n_tact_seen  = 1'b1;
                        end
                    end else if (!r_temp_seen) begin
                        n_temp_start = r_write_ptr;
                        n_temp_seen  = 1'b1;
                    end
                    step_addr = r_write_ptr;
                    if (region_full) begin
                        step_action = ACT_REJECT;
                    end else begin
                        step_action = ACT_PROGRAM;
                        step_data   = record_word;
                        n_write_ptr = ptr_next[ADDR_W-1:0];
                    end
                end else if (r_store[0] == r_code_erase) begin
                    step_action  = ACT_ERASE;
                    step_addr    = r_region_start;
                    n_write_ptr  = r_region_start;
                    n_ready_flag = 1'b0;
                end else if (r_store[0] == r_code_ready) begin
                    n_ready_flag = 1'b1;
                end
            end else if (r_receiving) begin
                // Store the byte, or mark the frame overrun and drop it
                if (r_frame_count < COUNT_W'(MESSAGE_LEN)) begin
                    store_we      = (r_frame_count < COUNT_W'(STORE_DEPTH));
                    n_frame_count = r_frame_count + COUNT_W'(1);
                end else begin
                    n_frame_count = COUNT_W'(MESSAGE_LEN + 1);
                end
            end
        end

        // A region start write reloads the pointer
        if (i_cfg_wr_en && t_reg_index'(i_cfg_index) == REG_REGION_START) begin
            n_write_ptr = i_cfg_data;
        end
    end

    // Control and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_start <= REGION_START_RST;
            r_region_size  <= REGION_SIZE_RST;
            r_region_end   <= {1'b0, REGION_START_RST} + (ADDR_W+1)'(REGION_SIZE_RST);
            r_code_tactile <= CODE_TACTILE_RST;
            r_code_temp    <= CODE_TEMP_RST;
            r_code_erase   <= CODE_ERASE_RST;
            r_code_ready   <= CODE_READY_RST;
            r_receiving    <= 1'b0;
            r_frame_count  <= '0;
            r_idle_ticks   <= '0;
            r_write_ptr    <= REGION_START_RST;
            r_tact_start   <= '0;
            r_tact_seen    <= 1'b0;
            r_temp_start   <= '0;
            r_temp_seen    <= 1'b0;
            r_ready_flag   <= 1'b0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_region_start <= n_region_start;
            r_region_size  <= n_region_size;
            r_region_end   <= n_region_end;
            r_code_tactile <= n_code_tactile;
            r_code_temp    <= n_code_temp;
            r_code_erase   <= n_code_erase;
            r_code_ready   <= n_code_ready;
            r_receiving    <= n_receiving;
            r_frame_count  <= n_frame_count;
            r_idle_ticks   <= n_idle_ticks;
            r_write_ptr    <= n_write_ptr;
            r_tact_start   <= n_tact_start;
            r_tact_seen    <= n_tact_seen;
            r_temp_start   <= n_temp_start;
            r_temp_seen    <= n_temp_seen;
            r_ready_flag   <= n_ready_flag;
            if (in_load) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frame byte store
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_frame_count[STORE_IDX_W-1:0]] <= r_in_byte;
        end
    end

    // Input and output payload registers
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_rx_byte;
        end
        if (advance) begin
            r_out_action     <= step_action;
            r_out_addr       <= step_addr;
            r_out_data       <= step_data;
            r_out_ready      <= n_ready_flag;
            r_out_tact_start <= n_tact_start;
            r_out_tact_seen  <= n_tact_seen;
            r_out_temp_start <= n_temp_start;
            r_out_temp_seen  <= n_temp_seen;
        end
    end

    assign o_valid                     = r_out_valid;
    assign o_action                    = r_out_action;
    assign o_flash_address             = r_out_addr;
    assign o_program_data              = r_out_data;
    assign o_config_ready              = r_out_ready;
    assign o_tactile_start_address     = r_out_tact_start;
    assign o_tactile_start_valid       = r_out_tact_seen;
    assign o_temperature_start_address = r_out_temp_start;
    assign o_temperature_start_valid   = r_out_temp_seen;

endmodule

`default_nettype wire
